// ===== rtl/block_transposition_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// block transposition cipher assertion macros
// shared property forms for the checks at the end of the gather and emit modules
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH
`define BLOCK_TRANSPOSITION_CIPHER_ASSERT_SVH

// same-cycle implication, idle while reset is asserted
`define BTC_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("btc assertion failed");

// next-cycle implication, idle while reset is asserted
`define BTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("btc assertion failed");

`endif

// ===== rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// types, register indexes and pattern tables of the block transposition cipher
// ----------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

    // default block store depth
    localparam int BTC_MAX_BLOCK = 16;

    // at the default depth the fill counter holds 0 to 15 and the result counter 0 to 16
    localparam int CNT_W = 5;

    // configuration register indexes
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_PATTERN   = 1'b1;

    // how a closed block is reordered
    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ENC,
        MODE_DEC
    } btc_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } btc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_done;
    } btc_out_t;

    // block handoff from the gather stage to the output buffer
    typedef struct packed {
        logic             load;
        logic             eom;
        btc_mode_t        mode;
        logic [2:0]       pat;
        logic [CNT_W-1:0] len;
    } btc_req_t;

    // block size of each pattern
    localparam logic [CNT_W-1:0] PAT_SIZE [8] = '{
        5'd10, 5'd13, 5'd13, 5'd16, 5'd8, 5'd15, 5'd12, 5'd12
    };

    // encode: output position k takes stored byte PAT_MAP[p][k]
    localparam logic [3:0] PAT_MAP [8][16] = '{
        '{4'd3, 4'd9, 4'd2, 4'd4, 4'd8, 4'd1, 4'd5, 4'd7,
          4'd0, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd12, 4'd1, 4'd11, 4'd2, 4'd6, 4'd10, 4'd3,
          4'd5, 4'd7, 4'd9, 4'd4, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd2, 4'd7, 4'd11, 4'd1, 4'd6, 4'd3, 4'd0, 4'd10,
          4'd12, 4'd5, 4'd9, 4'd4, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd12, 4'd7, 4'd9, 4'd1, 4'd4, 4'd15, 4'd5,
          4'd14, 4'd10, 4'd2, 4'd6, 4'd3, 4'd13, 4'd8, 4'd11},
        '{4'd3, 4'd1, 4'd7, 4'd4, 4'd0, 4'd6, 4'd2, 4'd5,
          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd13, 4'd9, 4'd14, 4'd1, 4'd5, 4'd2, 4'd10, 4'd8,
          4'd0, 4'd6, 4'd12, 4'd4, 4'd7, 4'd3, 4'd11, 4'd0},
        '{4'd7, 4'd10, 4'd11, 4'd4, 4'd3, 4'd2, 4'd6, 4'd1,
          4'd5, 4'd8, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd11, 4'd6, 4'd8, 4'd1, 4'd3, 4'd5, 4'd10, 4'd2,
          4'd7, 4'd0, 4'd4, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    // decode: inverse of each map, output position k takes stored byte PAT_INV[p][k]
    localparam logic [3:0] PAT_INV [8][16] = '{
        '{4'd8, 4'd5, 4'd2, 4'd0, 4'd3, 4'd6, 4'd9, 4'd7,
          4'd4, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd11, 4'd8, 4'd5, 4'd9,
          4'd12, 4'd10, 4'd6, 4'd3, 4'd1, 4'd0, 4'd0, 4'd0},
        '{4'd6, 4'd3, 4'd0, 4'd5, 4'd11, 4'd9, 4'd4, 4'd1,
          4'd12, 4'd10, 4'd7, 4'd2, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd4, 4'd10, 4'd12, 4'd5, 4'd7, 4'd11, 4'd2,
          4'd14, 4'd3, 4'd9, 4'd15, 4'd1, 4'd13, 4'd8, 4'd6},
        '{4'd4, 4'd1, 4'd6, 4'd0, 4'd3, 4'd7, 4'd5, 4'd2,
          4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd8, 4'd3, 4'd5, 4'd13, 4'd11, 4'd4, 4'd9, 4'd12,
          4'd7, 4'd1, 4'd6, 4'd14, 4'd10, 4'd0, 4'd2, 4'd0},
        '{4'd11, 4'd7, 4'd5, 4'd4, 4'd3, 4'd8, 4'd6, 4'd0,
          4'd9, 4'd10, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd9, 4'd3, 4'd7, 4'd4, 4'd10, 4'd5, 4'd1, 4'd8,
          4'd2, 4'd11, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

endpackage

`default_nettype wire

// ===== rtl/btc_gather.sv =====
// ----------------------------------------------------------------------------
// btc_gather
// collects input bytes into the block store and decides when a block closes
// ----------------------------------------------------------------------------
`default_nettype none

module btc_gather #(
    parameter int MAX_BLOCK = btc_pkg::BTC_MAX_BLOCK
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  btc_pkg::btc_in_t  s_data,
    input  logic              direction,
    input  logic [2:0]        pattern_sel,
    input  logic              emit_free,
    output btc_pkg::btc_req_t req,
    output logic [7:0]        blk [MAX_BLOCK]
);
    import btc_pkg::*;

    `include "block_transposition_cipher_assert.svh"

    localparam int IDX_W = $clog2(MAX_BLOCK);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    logic [7:0]       store_reg [MAX_BLOCK];
    logic [CNT_W-1:0] fill_cnt_reg;
    logic [CNT_W-1:0] fill_cnt_next;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] pat_size;
    logic [CNT_W-1:0] blk_size;
    logic             permute;
    logic             full;
    logic             close;
    logic             xfer;

    // block size in force; patterns larger than the store pass through
    always_comb begin
        pat_size = PAT_SIZE[pattern_sel];
        permute  = (pat_size <= MAX_CNT);
        blk_size = permute ? pat_size : MAX_CNT;
        fill_inc = fill_cnt_reg + CNT_W'(1);
        full     = (fill_inc >= blk_size);
        close    = full || s_data.end_of_message;
    end

    // a closing byte waits until the output buffer can take the block
    assign s_ready = emit_free || !close;
    assign xfer    = s_valid && s_ready;

    // block handoff
    always_comb begin
        req.load = xfer && close;
        req.eom  = s_data.end_of_message;
        req.pat  = pattern_sel;
        req.len  = full ? blk_size : fill_inc;
        if (!full || !permute) begin
            req.mode = MODE_PASS;
        end else if (direction) begin
            req.mode = MODE_DEC;
        end else begin
            req.mode = MODE_ENC;
        end
    end

    // stored bytes with the incoming byte merged at the fill position
    always_comb begin
        for (int i = 0; i < MAX_BLOCK; i++) begin
            blk[i] = (CNT_W'(i) == fill_cnt_reg) ? s_data.data_byte : store_reg[i];
        end
    end

    // fill count
    always_comb begin
        fill_cnt_next = fill_cnt_reg;
        if (xfer) begin
            fill_cnt_next = close ? '0 : fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
        end else begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // block store write
    always_ff @(posedge aclk) begin
        if (xfer) begin
            store_reg[fill_cnt_reg[IDX_W-1:0]] <= s_data.data_byte;
        end
    end

    // checks
    `BTC_ASSERT(a_fill_in_range, aclk, aresetn, 1'b1, fill_cnt_reg < MAX_CNT)
    `BTC_ASSERT(a_load_len, aclk, aresetn, req.load, req.len != '0 && req.len <= MAX_CNT)
    `BTC_ASSERT_NEXT(a_fill_adv, aclk, aresetn, xfer && !close, fill_cnt_reg == $past(fill_inc))

endmodule

`default_nettype wire

// ===== rtl/btc_permute.sv =====
// ----------------------------------------------------------------------------
// btc_permute
// reorders a closed block by the selected pattern, or keeps arrival order
// ----------------------------------------------------------------------------
`default_nettype none

module btc_permute #(
    parameter int MAX_BLOCK = btc_pkg::BTC_MAX_BLOCK
) (
    input  btc_pkg::btc_req_t req,
    input  logic [7:0]        blk  [MAX_BLOCK],
    output logic [7:0]        perm [MAX_BLOCK]
);
    import btc_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCK);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    logic [3:0] sel [MAX_BLOCK];

    // source position of each output byte
    always_comb begin
        for (int k = 0; k < MAX_BLOCK; k++) begin
            case (req.mode)
                MODE_ENC: sel[k] = PAT_MAP[req.pat][k];
                MODE_DEC: sel[k] = PAT_INV[req.pat][k];
                MODE_PASS: sel[k] = 4'(k);
                default: sel[k] = 4'(k);
            endcase
        end
    end

    // byte select per output position
    always_comb begin
        for (int k = 0; k < MAX_BLOCK; k++) begin
            if ({1'b0, sel[k]} < MAX_CNT) begin
                perm[k] = blk[sel[k][IDX_W-1:0]];
            end else begin
                perm[k] = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btc_emit.sv =====
// ----------------------------------------------------------------------------
// btc_emit
// output buffer: holds one reordered block and shifts it out a byte per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module btc_emit #(
    parameter int MAX_BLOCK = btc_pkg::BTC_MAX_BLOCK
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  btc_pkg::btc_req_t req,
    input  logic [7:0]        perm [MAX_BLOCK],
    output logic              emit_free,
    output logic              m_valid,
    input  logic              m_ready,
    output btc_pkg::btc_out_t m_data
);
    import btc_pkg::*;

    `include "block_transposition_cipher_assert.svh"

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    logic [7:0]       buf_reg [MAX_BLOCK];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             eom_reg;
    logic             last;
    logic             xfer;

    assign m_valid   = (count_reg != '0);
    assign last      = (count_reg == CNT_W'(1));
    assign xfer      = m_valid && m_ready;
    assign emit_free = !m_valid || (m_ready && last);

    // result fields
    always_comb begin
        m_data.out_byte     = buf_reg[0];
        m_data.run_last     = last;
        m_data.message_done = last && eom_reg;
    end

    // pending result count
    always_comb begin
        count_next = count_reg;
        if (req.load) begin
            count_next = req.len;
        end else if (xfer) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // block buffer, loaded whole and shifted toward the head on each transfer
    always_ff @(posedge aclk) begin
        if (req.load) begin
            buf_reg <= perm;
            eom_reg <= req.eom;
        end else if (xfer) begin
            for (int i = 0; i < MAX_BLOCK - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    // checks
    `BTC_ASSERT(a_load_when_free, aclk, aresetn, req.load, count_reg == '0 || (m_ready && last))
    `BTC_ASSERT(a_count_range, aclk, aresetn, 1'b1, count_reg <= MAX_CNT)
    `BTC_ASSERT_NEXT(a_load_shows, aclk, aresetn, req.load, m_valid && count_reg == $past(req.len))

endmodule

`default_nettype wire

// ===== rtl/block_transposition_cipher.sv =====
// ----------------------------------------------------------------------------
// block_transposition_cipher: one byte accepted per cycle; results one per cycle while m_ready is high.
// A closed block's first result shows the cycle after its last byte's transfer.
// A closing byte stalls until the output buffer is empty or its last result transfers.
// Synchronous active-low reset: counts and configuration registers cleared, store and buffer contents kept.
// ----------------------------------------------------------------------------
`default_nettype none

module block_transposition_cipher #(
    parameter int MAX_BLOCK = btc_pkg::BTC_MAX_BLOCK
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [2:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  btc_pkg::btc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output btc_pkg::btc_out_t m_data
);
    import btc_pkg::*;

    logic       direction_reg;
    logic [2:0] pattern_reg;
    logic       emit_free;
    btc_req_t   req;
    logic [7:0] blk  [MAX_BLOCK];
    logic [7:0] perm [MAX_BLOCK];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            pattern_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIRECTION: direction_reg <= cfg_wr_data[0];
                REG_PATTERN: pattern_reg <= cfg_wr_data;
                default: pattern_reg <= pattern_reg;
            endcase
        end
    end

    // byte collection
    btc_gather #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_gather (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .direction  (direction_reg),
        .pattern_sel(pattern_reg),
        .emit_free  (emit_free),
        .req        (req),
        .blk        (blk)
    );

    // block reorder
    btc_permute #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_permute (
        .req (req),
        .blk (blk),
        .perm(perm)
    );

    // result buffer
    btc_emit #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .perm     (perm),
        .emit_free(emit_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
